[rtl/midi_clock_tempo_tracker_top_assert.svh]
// assertion macros shared by the tempo tracker rtl
`ifndef MIDI_CLOCK_TEMPO_TRACKER_TOP_ASSERT_SVH
`define MIDI_CLOCK_TEMPO_TRACKER_TOP_ASSERT_SVH

// property checked on every clock edge outside reset
`define MCTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be seen
`define MCTT_ASSERT_NEVER(lbl, cond, msg) \
    `MCTT_ASSERT(lbl, !(cond), msg)

`endif

[rtl/mctt_pkg.sv]
// constants and types shared by the tempo tracker modules
`timescale 1ns / 1ps

package mctt_pkg;

    localparam int TIME_W           = 32;
    localparam longint TICKS_PER_SECOND = 1000000;

    // 60 s worth of ticks in 26.8 fixed point
    localparam logic [63:0] NUMER_FULL = 64'(60) * 64'(TICKS_PER_SECOND) * 64'd256;
    localparam int DVD_W = $clog2(NUMER_FULL + 64'd1);
    localparam int DVS_W = TIME_W;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [DVD_W-1:0] NUMER = DVD_W'(NUMER_FULL);

    localparam int TEMPO_W  = 24;
    localparam int POS_W    = 32;
    localparam int PPQ_W    = 10;
    localparam int BPB_W    = 5;
    localparam int MIN_W    = 9;
    localparam int PULSE_W  = 14;
    localparam int BAR_W    = PPQ_W + BPB_W;
    localparam int CFG_DATA_W = PPQ_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TEMPO_W-1:0] TEMPO_MAX   = {TEMPO_W{1'b1}};
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(23040);
    localparam logic [PPQ_W-1:0]   PPQ_RESET   = PPQ_W'(24);
    localparam logic [BPB_W-1:0]   BPB_RESET   = BPB_W'(4);
    localparam logic [MIN_W-1:0]   MIN_RESET   = MIN_W'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PPQ       = 2'd0,
        CFG_BPB       = 2'd1,
        CFG_MIN_TEMPO = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/mctt_div.sv]
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module mctt_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mctt_pkg::div_ctrl_t        ctrl,
    input  logic [mctt_pkg::DVD_W-1:0] dividend,
    input  logic [mctt_pkg::DVS_W-1:0] divisor,
    output mctt_pkg::div_stat_t        stat,
    output logic [mctt_pkg::DVD_W-1:0] quotient
);
    import mctt_pkg::*;

    `include "midi_clock_tempo_tracker_top_assert.svh"

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVS_W:0]      rem_sh;
    logic [DVS_W+1:0]    diff;

    // shift in the next dividend bit and try the subtract
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (ctrl.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DVS_W+1]) begin
                rem_next = diff[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

    `MCTT_ASSERT(div_start_busy, ctrl.start && !busy_reg |=> busy_reg, "divider did not start")
    `MCTT_ASSERT_NEVER(div_done_while_busy, done_reg && busy_reg, "divider done while busy")
    `MCTT_ASSERT_NEVER(div_busy_no_count, busy_reg && (cnt_reg == '0), "divider busy with no steps")

endmodule

[rtl/midi_clock_tempo_tracker_top.sv]
// midi clock tempo tracker: tempo, song position and bar tracking per clock pulse
// each result is set by two passes of the shared 34-step divider
// (60 s / ppq, then by elapsed ticks); input is not ready while working
// reset: aresetn synchronous active low, sets control registers to their defaults
`timescale 1ns / 1ps

module midi_clock_tempo_tracker_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mctt_pkg::TIME_W-1:0]     s_event_time,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mctt_pkg::TEMPO_W-1:0]    m_tempo_fixed,
    output logic [mctt_pkg::POS_W-1:0]      m_position_pulses,
    output logic [mctt_pkg::POS_W-1:0]      m_bar_start_pulses,
    output logic [mctt_pkg::TIME_W-1:0]     m_last_event_time,
    output logic                            m_resynced,
    output logic                            m_bar_boundary,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mctt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mctt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mctt_pkg::*;

    `include "midi_clock_tempo_tracker_top_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START1,
        ST_WAIT1,
        ST_START2,
        ST_WAIT2,
        ST_UPDATE,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [PPQ_W-1:0]    ppq_reg, ppq_next;
    logic [BPB_W-1:0]    bpb_reg, bpb_next;
    logic [MIN_W-1:0]    min_reg, min_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [TEMPO_W-1:0]  tempo_reg, tempo_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    bar_start_reg, bar_start_next;
    logic [PULSE_W-1:0]  pulse_reg, pulse_next;
    logic                stall_reg, stall_next;
    logic                boundary_reg, boundary_next;

    logic                m_valid_reg, m_valid_next;
    logic [TEMPO_W-1:0]  m_tempo_reg, m_tempo_next;
    logic [POS_W-1:0]    m_pos_reg, m_pos_next;
    logic [POS_W-1:0]    m_bar_reg, m_bar_next;
    logic [TIME_W-1:0]   m_time_reg, m_time_next;
    logic                m_resync_reg, m_resync_next;
    logic                m_boundary_reg, m_boundary_next;

    div_ctrl_t           div_ctrl;
    div_stat_t           div_stat;
    logic [DVD_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic [DVD_W-1:0]    div_quotient;

    logic [PPQ_W-1:0]    ppq_eff;
    logic [BPB_W-1:0]    bpb_eff;
    logic [BAR_W-1:0]    bar_len;
    logic [BAR_W-1:0]    pulse_inc;
    logic [TEMPO_W-1:0]  tempo_calc;
    logic                stall;

    mctt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // zero ppq or beats per bar count as one
    assign ppq_eff   = (ppq_reg == '0) ? PPQ_W'(1) : ppq_reg;
    assign bpb_eff   = (bpb_reg == '0) ? BPB_W'(1) : bpb_reg;
    assign bar_len   = BAR_W'(ppq_eff) * BAR_W'(bpb_eff);
    assign pulse_inc = BAR_W'(pulse_reg) + BAR_W'(1);

    // saturate on zero elapsed or a quotient past 16.8 range
    assign tempo_calc = ((elapsed_reg == '0) || (|div_quotient[DVD_W-1:TEMPO_W]))
                        ? TEMPO_MAX : div_quotient[TEMPO_W-1:0];
    assign stall      = tempo_calc < TEMPO_W'({min_reg, 8'h00});

    assign div_dividend = (state_reg == ST_START1) ? NUMER : div_quotient;
    assign div_divisor  = (state_reg == ST_START1) ? DVS_W'(ppq_eff) : elapsed_reg;

    always_comb begin
        state_next      = state_reg;
        ppq_next        = ppq_reg;
        bpb_next        = bpb_reg;
        min_next        = min_reg;
        last_time_next  = last_time_reg;
        now_next        = now_reg;
        elapsed_next    = elapsed_reg;
        tempo_next      = tempo_reg;
        pos_next        = pos_reg;
        bar_start_next  = bar_start_reg;
        pulse_next      = pulse_reg;
        stall_next      = stall_reg;
        boundary_next   = boundary_reg;
        m_valid_next    = m_valid_reg;
        m_tempo_next    = m_tempo_reg;
        m_pos_next      = m_pos_reg;
        m_bar_next      = m_bar_reg;
        m_time_next     = m_time_reg;
        m_resync_next   = m_resync_reg;
        m_boundary_next = m_boundary_reg;
        div_ctrl.start  = 1'b0;

        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PPQ:       ppq_next = cfg_data[PPQ_W-1:0];
                CFG_BPB:       bpb_next = cfg_data[BPB_W-1:0];
                CFG_MIN_TEMPO: min_next = cfg_data[MIN_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_next     = s_event_time;
                    elapsed_next = s_event_time - last_time_reg;
                    state_next   = ST_START1;
                end
            end
            ST_START1: begin
                div_ctrl.start = 1'b1;
                state_next     = ST_WAIT1;
            end
            ST_WAIT1: begin
                if (div_stat.done) begin
                    state_next = ST_START2;
                end
            end
            ST_START2: begin
                div_ctrl.start = 1'b1;
                state_next     = ST_WAIT2;
            end
            ST_WAIT2: begin
                if (div_stat.done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                last_time_next = now_reg;
                stall_next     = stall;
                boundary_next  = 1'b0;
                if (stall) begin
                    // freewheel: clear position, keep held tempo
                    pos_next       = '0;
                    bar_start_next = '0;
                    pulse_next     = '0;
                end else begin
                    tempo_next = tempo_calc;
                    pos_next   = pos_reg + POS_W'(1);
                    // bar length is capped at the range of the 14-bit pulse counter
                    if ((pulse_inc >= bar_len) || pulse_inc[PULSE_W]) begin
                        pulse_next     = '0;
                        bar_start_next = pos_reg + POS_W'(1);
                        boundary_next  = 1'b1;
                    end else begin
                        pulse_next = pulse_inc[PULSE_W-1:0];
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_tempo_next    = tempo_reg;
                    m_pos_next      = pos_reg;
                    m_bar_next      = bar_start_reg;
                    m_time_next     = now_reg;
                    m_resync_next   = stall_reg;
                    m_boundary_next = boundary_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ppq_reg       <= PPQ_RESET;
            bpb_reg       <= BPB_RESET;
            min_reg       <= MIN_RESET;
            last_time_reg <= '0;
            tempo_reg     <= TEMPO_RESET;
            pos_reg       <= '0;
            bar_start_reg <= '0;
            pulse_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ppq_reg       <= ppq_next;
            bpb_reg       <= bpb_next;
            min_reg       <= min_next;
            last_time_reg <= last_time_next;
            tempo_reg     <= tempo_next;
            pos_reg       <= pos_next;
            bar_start_reg <= bar_start_next;
            pulse_reg     <= pulse_next;
            m_valid_reg   <= m_valid_next;
        end
        now_reg        <= now_next;
        elapsed_reg    <= elapsed_next;
        stall_reg      <= stall_next;
        boundary_reg   <= boundary_next;
        m_tempo_reg    <= m_tempo_next;
        m_pos_reg      <= m_pos_next;
        m_bar_reg      <= m_bar_next;
        m_time_reg     <= m_time_next;
        m_resync_reg   <= m_resync_next;
        m_boundary_reg <= m_boundary_next;
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign cfg_ready          = 1'b1;
    assign m_valid            = m_valid_reg;
    assign m_tempo_fixed      = m_tempo_reg;
    assign m_position_pulses  = m_pos_reg;
    assign m_bar_start_pulses = m_bar_reg;
    assign m_last_event_time  = m_time_reg;
    assign m_resynced         = m_resync_reg;
    assign m_bar_boundary     = m_boundary_reg;

    `MCTT_ASSERT(top_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready after transfer")
    `MCTT_ASSERT_NEVER(top_resync_state,
        m_valid && m_resynced && (m_bar_boundary || (m_position_pulses != '0)),
        "resync result not cleared")
    `MCTT_ASSERT(top_bar_latch,
        m_valid && m_bar_boundary |-> m_bar_start_pulses == m_position_pulses,
        "bar start not latched")

endmodule

[test/mctt_tempo_checker.sv]
// scoreboard for the tempo tracker: predicts every pulse report and compares the outputs
`timescale 1ns / 1ps

module mctt_tempo_checker
    import mctt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [TIME_W-1:0]     s_event_time,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [TEMPO_W-1:0]    m_tempo_fixed,
    input  logic [POS_W-1:0]      m_position_pulses,
    input  logic [POS_W-1:0]      m_bar_start_pulses,
    input  logic [TIME_W-1:0]     m_last_event_time,
    input  logic                  m_resynced,
    input  logic                  m_bar_boundary,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    reports_pending
);

    // one minute of microsecond ticks, scaled to 26.8 fixed point
    localparam longint unsigned MINUTE_Q8  = 64'd15_360_000_000;
    localparam longint unsigned TEMPO_CEIL = 64'hFF_FFFF;
    localparam longint unsigned BAR_LIMIT  = 64'd16384;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   bar_start;
        logic [TIME_W-1:0]  stamp;
        logic               resync;
        logic               boundary;
    } pulse_report_t;

    logic [PPQ_W-1:0]   ppq_setting;
    logic [BPB_W-1:0]   bpb_setting;
    logic [MIN_W-1:0]   floor_bpm;
    logic [TIME_W-1:0]  prev_stamp;
    logic [TEMPO_W-1:0] held_tempo;
    logic [POS_W-1:0]   song_pos;
    logic [POS_W-1:0]   bar_anchor;
    int unsigned        bar_pulse;

    pulse_report_t expected_reports[$];

    initial begin
        mismatch_count  = 0;
        reports_pending = 0;
    end

    task automatic track_pulse(input logic [TIME_W-1:0] stamp, output pulse_report_t rpt);
        logic [TIME_W-1:0] elapsed;
        longint unsigned   ppq;
        longint unsigned   bar_len;
        longint unsigned   rate;
        logic              stall;
        elapsed = stamp - prev_stamp;
        ppq = (ppq_setting == 0) ? 64'd1 : 64'(ppq_setting);
        bar_len = ppq * ((bpb_setting == 0) ? 64'd1 : 64'(bpb_setting));
        if (bar_len > BAR_LIMIT) begin
            bar_len = BAR_LIMIT;
        end
        if (elapsed == 0) begin
            rate = TEMPO_CEIL;
        end else begin
            rate = (MINUTE_Q8 / ppq) / 64'(elapsed);
            if (rate > TEMPO_CEIL) begin
                rate = TEMPO_CEIL;
            end
        end
        // stall test is on the fresh tempo, not the held one
        stall = rate < 64'(floor_bpm) * 64'd256;
        rpt.boundary = 1'b0;
        if (stall) begin
            song_pos   = '0;
            bar_anchor = '0;
            bar_pulse  = 0;
        end else begin
            held_tempo = rate[TEMPO_W-1:0];
            song_pos   = song_pos + 1'b1;
            bar_pulse++;
            // a shrunk bar wraps as soon as the count reaches the new length
            if (bar_pulse >= bar_len) begin
                bar_pulse    = 0;
                bar_anchor   = song_pos;
                rpt.boundary = 1'b1;
            end
        end
        prev_stamp    = stamp;
        rpt.tempo     = held_tempo;
        rpt.position  = song_pos;
        rpt.bar_start = bar_anchor;
        rpt.stamp     = stamp;
        rpt.resync    = stall;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("checker: %s expected %0d, got %0d at %0t", what, want, got, $realtime);
            end
        end
    endtask

    always @(posedge aclk) begin : monitor
        pulse_report_t want;
        if (!aresetn) begin
            ppq_setting = PPQ_RESET;
            bpb_setting = BPB_RESET;
            floor_bpm   = MIN_RESET;
            prev_stamp  = '0;
            held_tempo  = TEMPO_RESET;
            song_pos    = '0;
            bar_anchor  = '0;
            bar_pulse   = 0;
            expected_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PPQ: begin
                        ppq_setting = cfg_data[PPQ_W-1:0];
                    end
                    CFG_BPB: begin
                        bpb_setting = cfg_data[BPB_W-1:0];
                    end
                    CFG_MIN_TEMPO: begin
                        floor_bpm = cfg_data[MIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                track_pulse(s_event_time, want);
                expected_reports.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("checker: result transfer with nothing pending at %0t",
                                 $realtime);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    check_field("tempo_fixed", 64'(m_tempo_fixed), 64'(want.tempo));
                    check_field("position_pulses", 64'(m_position_pulses), 64'(want.position));
                    check_field("bar_start_pulses", 64'(m_bar_start_pulses),
                                64'(want.bar_start));
                    check_field("last_event_time", 64'(m_last_event_time), 64'(want.stamp));
                    check_field("resynced", 64'(m_resynced), 64'(want.resync));
                    check_field("bar_boundary", 64'(m_bar_boundary), 64'(want.boundary));
                end
            end
        end
        reports_pending = expected_reports.size();
    end

endmodule

[test/tb.sv]
// testbench top for the tempo tracker: clock, reset, pulse and register stimulus, verdict
`timescale 1ns / 1ps

module tb;
    import mctt_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int PHASE_ITEMS = 65;
    localparam int PHASES      = 10;
    // one minute of microsecond ticks, scaled to 26.8 fixed point
    localparam longint unsigned MINUTE_Q8 = 64'd15_360_000_000;
    localparam cfg_idx_t CFG_UNMAPPED = cfg_idx_t'(2'd3);

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [TIME_W-1:0]     s_event_time = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [TEMPO_W-1:0]    m_tempo_fixed;
    logic [POS_W-1:0]      m_position_pulses;
    logic [POS_W-1:0]      m_bar_start_pulses;
    logic [TIME_W-1:0]     m_last_event_time;
    logic                  m_resynced;
    logic                  m_bar_boundary;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index    = CFG_PPQ;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int mismatch_count;
    int reports_pending;

    logic              steady        = 1'b0;
    int                pulses_sent   = 0;
    int                results_taken = 0;
    int                quiet_cycles  = 0;
    logic [TIME_W-1:0] prev_stamp    = '0;
    longint unsigned   gap_ppq       = 24;
    longint unsigned   gap_min       = 20;

    int unsigned phase_ppq [PHASES] = '{24, 1, 960, 3, 0, 2, 1023, 12, 6, 4};
    int unsigned phase_bpb [PHASES] = '{4, 1, 16, 2, 0, 3, 31, 5, 7, 0};
    int unsigned phase_min [PHASES] = '{20, 1, 300, 0, 5, 40, 511, 100, 2, 60};

    midi_clock_tempo_tracker_top DUT (.*);

    mctt_tempo_checker tempo_check (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 17);
        end
        if (m_valid && m_ready) begin
            results_taken <= results_taken + 1;
        end
    end

    // watchdog: cycles without any transfer on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // largest gap that still keeps the tempo at or above the minimum
    function automatic logic [TIME_W-1:0] longest_steady_gap();
        longint unsigned span;
        if (gap_min == 0) begin
            return '1;
        end
        span = (MINUTE_Q8 / gap_ppq) / (gap_min * 64'd256);
        return (span > 64'hFFFF_FFFF) ? '1 : span[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] next_stamp();
        logic [TIME_W-1:0] limit;
        int unsigned       pick;
        limit = longest_steady_gap();
        pick  = $urandom_range(99);
        if (pick < 70) begin
            return prev_stamp + ($urandom_range(limit, 1) >> $urandom_range(3, 0));
        end else if (pick < 78) begin
            return prev_stamp + $urandom_range(12, 0);
        end else if (pick < 86) begin
            return prev_stamp + limit + $urandom_range(1, 0);
        end else if (pick < 93) begin
            return prev_stamp + limit + $urandom_range(10_000_000, 1);
        end
        return $urandom();
    endfunction

    task automatic send_pulse(input logic [TIME_W-1:0] stamp);
        while (!steady && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_event_time <= stamp;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        prev_stamp = stamp;
        pulses_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (results_taken != pulses_sent) begin
            @(posedge aclk);
        end
    endtask

    // valid stays up across back-to-back register transfers
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_tempo_regs(input logic [CFG_DATA_W-1:0] ppq,
                                  input logic [CFG_DATA_W-1:0] bpb,
                                  input logic [CFG_DATA_W-1:0] minimum);
        wait_drained();
        write_reg(CFG_PPQ, ppq);
        write_reg(CFG_BPB, bpb);
        write_reg(CFG_MIN_TEMPO, minimum);
        cfg_valid <= 1'b0;
        gap_ppq = (ppq[PPQ_W-1:0] == 0) ? 64'd1 : 64'(ppq[PPQ_W-1:0]);
        gap_min = 64'(minimum[MIN_W-1:0]);
    endtask

    initial begin : stimulus
        int ph;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first pulse measures from time zero; then tiny, huge and wrapping gaps
        send_pulse('0);
        send_pulse(32'd5);
        send_pulse('1);
        send_pulse('0);
        send_pulse(32'd20833);
        send_pulse(prev_stamp + longest_steady_gap());
        send_pulse(prev_stamp + longest_steady_gap() + 1'b1);
        send_pulse(prev_stamp + 32'd41666);

        // unmapped index must leave every setting alone
        wait_drained();
        write_reg(CFG_UNMAPPED, '1);
        // one-pulse bar: every pulse is a boundary, and the old count is past it
        set_tempo_regs(1, 1, 1);
        repeat (3) send_pulse(prev_stamp + 32'd1000);
        // zero registers count as one, zero minimum never stalls
        set_tempo_regs(0, 0, 0);
        send_pulse(prev_stamp + 32'hFFFF_FFFF);
        send_pulse(prev_stamp + 32'd1);
        // largest register values, bar length capped
        set_tempo_regs(1023, 31, 511);
        send_pulse(prev_stamp + longest_steady_gap());
        send_pulse(prev_stamp + longest_steady_gap() + 1'b1);
        send_pulse(prev_stamp + 32'd50);
        set_tempo_regs(960, 16, 300);
        send_pulse(prev_stamp + longest_steady_gap());
        send_pulse(prev_stamp + longest_steady_gap() + 1'b1);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph >= 8) begin
                set_tempo_regs(CFG_DATA_W'($urandom_range(8, 1)),
                               CFG_DATA_W'($urandom_range(4, 0)),
                               CFG_DATA_W'($urandom_range(80, 0)));
            end else begin
                set_tempo_regs(CFG_DATA_W'(phase_ppq[ph]), CFG_DATA_W'(phase_bpb[ph]),
                               CFG_DATA_W'(phase_min[ph]));
            end
            steady <= (ph == 4 || ph == 5);
            repeat (PHASE_ITEMS) send_pulse(next_stamp());
        end

        steady <= 1'b0;
        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && reports_pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/mctt_pkg.sv
rtl/mctt_div.sv
rtl/midi_clock_tempo_tracker_top.sv
test/mctt_tempo_checker.sv
test/tb.sv
